// ===== hw/rtl/bmfn_pkg.sv =====
package bmfn_pkg;

  localparam int WORD_W = 64;
  localparam int OFF_W  = 6;
  localparam int IDX_W  = 10;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2,
    MODE_FIND  = 2'd3
  } mode_t;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CLEAR  = 5'b00010,
    S_ACCESS = 5'b00100,
    S_SCAN   = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  // lowest set bit of a word
  function automatic logic [OFF_W-1:0] lowest_set(input logic [WORD_W-1:0] w);
    logic [OFF_W-1:0] pos;
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) begin
        pos = OFF_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

// ===== hw/rtl/bmfn_ram.sv =====
module bmfn_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/bit_map_find_next_top.sv =====
// Bit map with clear, write, read and find-next requests, one result per
// request. The flags sit in a single-port-read memory of 64-bit words, and
// every operation moves through it one word per cycle. A write or read
// accesses one word. A find scans the words from the start word up to the
// first hit (at most NUM_BITS/64, 16 at the default size). A clear zeroes
// every word in one sweep; the same zeroing sweep runs after reset, during
// which no request is accepted. A request may be taken while the previous
// result still waits on the output.
module bit_map_find_next_top
  import bmfn_pkg::*;
#(
  parameter int NUM_BITS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // mode[1:0], bit_index[11:2], bit_value[12], zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // read_value[0], found[1], found_index[11:2], zero
);

  localparam int NUM_WORDS = (NUM_BITS + WORD_W - 1) / WORD_W;
  localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int TAIL_BITS = NUM_BITS - (NUM_WORDS - 1) * WORD_W;
  localparam logic [ADDR_W-1:0] LAST = ADDR_W'(NUM_WORDS - 1);
  localparam logic [WORD_W-1:0] TAIL_MASK = {WORD_W{1'b1}} >> (WORD_W - TAIL_BITS);

  state_t state, state_next;

  logic [ADDR_W-1:0] ptr;
  logic              scan_first;
  logic              clr_req;
  mode_t             op_mode;
  logic [OFF_W-1:0]  op_off;
  logic              op_val;

  logic              res_read;
  logic              res_found;
  logic [IDX_W-1:0]  res_index;

  mode_t             in_mode;
  logic [IDX_W-1:0]  in_idx;
  logic              in_val;
  logic [31:0]       in_idx32;
  logic              in_ok;
  logic [ADDR_W-1:0] in_word;
  logic              accept;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  logic [ADDR_W-1:0] ptr_inc;
  logic [WORD_W-1:0] match;
  logic              hit;
  logic [OFF_W-1:0]  hit_pos;
  logic [31:0]       hit_idx32;
  logic              out_load;

  assign in_mode  = mode_t'(s_tdata[1:0]);
  assign in_idx   = s_tdata[11:2];
  assign in_val   = s_tdata[12];
  assign in_idx32 = 32'(in_idx);
  assign in_ok    = in_idx32 < 32'(NUM_BITS);
  assign in_word  = in_idx32[OFF_W +: ADDR_W];

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  assign ptr_inc  = (ptr == LAST) ? ptr : ptr + ADDR_W'(1);

  assign match = (ram_rdata ^ {WORD_W{~op_val}})
               & (scan_first ? ({WORD_W{1'b1}} << op_off) : {WORD_W{1'b1}})
               & ((ptr == LAST) ? TAIL_MASK : {WORD_W{1'b1}});
  assign hit       = |match;
  assign hit_pos   = lowest_set(match);
  assign hit_idx32 = 32'({ptr, hit_pos});

  assign out_load = (state == S_DONE) && (!m_tvalid || m_tready);

  always_comb begin
    ram_raddr = (state == S_IDLE) ? in_word : ptr_inc;
    ram_we    = 1'b0;
    ram_waddr = ptr;
    ram_wdata = '0;
    if (state == S_CLEAR) begin
      ram_we = 1'b1;
    end else if (state == S_ACCESS && op_mode == MODE_WRITE) begin
      ram_we    = 1'b1;
      ram_wdata = (ram_rdata & ~({{(WORD_W-1){1'b0}}, 1'b1} << op_off))
                | ({{(WORD_W-1){1'b0}}, op_val} << op_off);
    end
  end

  bmfn_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_WORDS),
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (in_mode)
            MODE_CLEAR: state_next = S_CLEAR;
            MODE_WRITE,
            MODE_READ:  state_next = in_ok ? S_ACCESS : S_DONE;
            MODE_FIND:  state_next = in_ok ? S_SCAN : S_DONE;
            default:    state_next = S_DONE;
          endcase
        end
      end
      S_CLEAR: begin
        if (ptr == LAST) begin
          state_next = clr_req ? S_DONE : S_IDLE;
        end
      end
      S_ACCESS: state_next = S_DONE;
      S_SCAN: begin
        if (hit || ptr == LAST) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      ptr      <= '0;
      clr_req  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            clr_req <= (in_mode == MODE_CLEAR);
            ptr     <= (in_mode == MODE_CLEAR) ? '0 : in_word;
          end
        end
        S_CLEAR: ptr <= ptr_inc;
        S_SCAN: begin
          if (!hit) begin
            ptr <= ptr_inc;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_mode    <= in_mode;
      op_off     <= in_idx32[OFF_W-1:0];
      op_val     <= in_val;
      scan_first <= 1'b1;
      res_read   <= 1'b0;
      res_found  <= 1'b0;
      res_index  <= '0;
    end
    if (state == S_ACCESS && op_mode == MODE_READ) begin
      res_read <= ram_rdata[op_off];
    end
    if (state == S_SCAN) begin
      scan_first <= 1'b0;
      if (hit) begin
        res_found <= 1'b1;
        res_index <= hit_idx32[IDX_W-1:0];
      end
    end
    if (out_load) begin
      m_tdata <= {4'b0, res_index, res_found, res_read};
    end
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import bmfn_pkg::*;

  localparam int MAP_BITS    = 1024;
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_DIR       = 23;
  localparam int N_PHASES    = 4;
  localparam int PHASE_ITEMS = 205;

  typedef struct packed {
    mode_t            mode;
    logic [IDX_W-1:0] bit_index;
    logic             bit_value;
  } bm_req_t;

  typedef struct packed {
    logic             read_value;
    logic             found;
    logic [IDX_W-1:0] found_index;
  } bm_result_t;

  typedef struct packed {
    bm_req_t    req;
    logic       typed;
    bm_result_t result;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  logic       flag_map [MAP_BITS];
  bm_result_t result_q [$];
  int         errors = 0;
  int         items_sent = 0;
  int         cycle_count = 0;
  int         sender_idle_pct = 0;
  int         recv_stall_pct = 0;

  int sender_pct [N_PHASES] = '{0, 71, 0, 9};
  int stall_pct  [N_PHASES] = '{0, 0, 71, 9};

  // typed rows: after reset, extremes, no-match finds, clear
  dir_row_t dir_rows [N_DIR] = '{
    '{'{MODE_READ,  10'd0,    1'b0}, 1'b1, '{1'b0, 1'b0, 10'd0}},
    '{'{MODE_READ,  10'd1023, 1'b0}, 1'b1, '{1'b0, 1'b0, 10'd0}},
    '{'{MODE_FIND,  10'd0,    1'b0}, 1'b1, '{1'b0, 1'b1, 10'd0}},
    '{'{MODE_FIND,  10'd1023, 1'b0}, 1'b1, '{1'b0, 1'b1, 10'd1023}},
    '{'{MODE_FIND,  10'd0,    1'b1}, 1'b1, '{1'b0, 1'b0, 10'd0}},
    '{'{MODE_WRITE, 10'd1023, 1'b1}, 1'b1, '{1'b0, 1'b0, 10'd0}},
    '{'{MODE_FIND,  10'd0,    1'b1}, 1'b1, '{1'b0, 1'b1, 10'd1023}},
    '{'{MODE_FIND,  10'd1023, 1'b0}, 1'b1, '{1'b0, 1'b0, 10'd0}},
    '{'{MODE_READ,  10'd1023, 1'b0}, 1'b1, '{1'b1, 1'b0, 10'd0}},
    '{'{MODE_WRITE, 10'd0,    1'b1}, 1'b1, '{1'b0, 1'b0, 10'd0}},
    '{'{MODE_WRITE, 10'd63,   1'b1}, 1'b0, '0},
    '{'{MODE_WRITE, 10'd64,   1'b1}, 1'b0, '0},
    '{'{MODE_FIND,  10'd0,    1'b0}, 1'b0, '0},
    '{'{MODE_FIND,  10'd1,    1'b1}, 1'b0, '0},
    '{'{MODE_FIND,  10'd64,   1'b0}, 1'b0, '0},
    '{'{MODE_WRITE, 10'd682,  1'b1}, 1'b0, '0},
    '{'{MODE_FIND,  10'd341,  1'b1}, 1'b0, '0},
    '{'{MODE_READ,  10'd682,  1'b1}, 1'b0, '0},
    '{'{MODE_WRITE, 10'd0,    1'b0}, 1'b0, '0},
    '{'{MODE_CLEAR, 10'd0,    1'b0}, 1'b1, '{1'b0, 1'b0, 10'd0}},
    '{'{MODE_FIND,  10'd0,    1'b1}, 1'b1, '{1'b0, 1'b0, 10'd0}},
    '{'{MODE_READ,  10'd64,   1'b0}, 1'b1, '{1'b0, 1'b0, 10'd0}},
    '{'{MODE_CLEAR, 10'd1023, 1'b1}, 1'b1, '{1'b0, 1'b0, 10'd0}}
  };

  bit_map_find_next_top #(
    .NUM_BITS(MAP_BITS)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < MAP_BITS; i++) flag_map[i] = 1'b0;
  end

  // updates the flag map and returns the result a request yields
  function automatic bm_result_t flag_map_result(input bm_req_t req);
    bm_result_t res;
    int         pos;
    res = '0;
    pos = int'(req.bit_index);
    case (req.mode)
      MODE_CLEAR: begin
        for (int i = 0; i < MAP_BITS; i++) flag_map[i] = 1'b0;
      end
      MODE_WRITE: begin
        if (pos < MAP_BITS) flag_map[pos] = req.bit_value;
      end
      MODE_READ: begin
        if (pos < MAP_BITS) res.read_value = flag_map[pos];
      end
      default: begin
        while (pos < MAP_BITS && flag_map[pos] != req.bit_value) pos++;
        if (pos < MAP_BITS) begin
          res.found       = 1'b1;
          res.found_index = IDX_W'(pos);
        end
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    bm_result_t got;
    bm_result_t want;
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst && m_tvalid && m_tready) begin
      got.read_value  = m_tdata[0];
      got.found       = m_tdata[1];
      got.found_index = m_tdata[11:2];
      if (result_q.size() == 0) begin
        report_mismatch("result with no request pending");
      end else begin
        want = result_q.pop_front();
        if (got.read_value !== want.read_value)
          report_mismatch($sformatf("read_value %b, want %b", got.read_value,
                                    want.read_value));
        if (got.found !== want.found)
          report_mismatch($sformatf("found %b, want %b", got.found, want.found));
        if (got.found_index !== want.found_index)
          report_mismatch($sformatf("found_index %0d, want %0d", got.found_index,
                                    want.found_index));
      end
    end
  end

  task automatic send_req(input bm_req_t req, input logic typed,
                          input bm_result_t typed_res);
    bm_result_t pred;
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, req.bit_value, req.bit_index, req.mode};
    do @(posedge clk); while (!s_tready);
    pred = flag_map_result(req);
    result_q.push_back(typed ? typed_res : pred);
    items_sent++;
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (result_q.size() != 0);
  endtask

  task automatic run_random(input int target);
    int      first;
    int      r;
    int      base;
    int      len;
    logic    v;
    bm_req_t req;
    first = items_sent;
    while (items_sent - first < target) begin
      r = $urandom_range(99);
      req.bit_index = IDX_W'($urandom_range(MAP_BITS - 1));
      req.bit_value = 1'($urandom_range(1));
      if (r < 4) begin
        // contiguous run of equal flags, then search across it
        base = $urandom_range(MAP_BITS - 1);
        len  = ($urandom_range(3) == 0) ? $urandom_range(130, 65) : $urandom_range(12, 1);
        v    = 1'($urandom_range(1));
        req.mode      = MODE_WRITE;
        req.bit_value = v;
        for (int k = base; k < base + len && k < MAP_BITS; k++) begin
          req.bit_index = IDX_W'(k);
          send_req(req, 1'b0, '0);
        end
        req.mode      = MODE_FIND;
        req.bit_index = IDX_W'(base);
        req.bit_value = ~v;
        send_req(req, 1'b0, '0);
        req.bit_value = v;
        send_req(req, 1'b0, '0);
      end else begin
        if (r < 6) begin
          req.mode = MODE_CLEAR;
        end else if (r < 42) begin
          req.mode      = MODE_WRITE;
          req.bit_value = ($urandom_range(99) < 60);
        end else if (r < 62) begin
          req.mode = MODE_READ;
        end else begin
          req.mode = MODE_FIND;
        end
        send_req(req, 1'b0, '0);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    for (int n = 0; n < N_DIR; n++) begin
      send_req(dir_rows[n].req, dir_rows[n].typed, dir_rows[n].result);
    end
    for (int p = 0; p < N_PHASES; p++) begin
      drain_results();
      sender_idle_pct = sender_pct[p];
      recv_stall_pct  = stall_pct[p];
      run_random(PHASE_ITEMS);
    end
    drain_results();
    repeat (40) @(posedge clk);
    if (result_q.size() != 0) report_mismatch("results still pending at end");
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
